[design/wbps_pkg.sv]
package wbps_pkg;

  // Widths fixed by the register map and the item fields.
  localparam int unsigned PatternBytes = 16;
  localparam int unsigned LenW         = 5;
  localparam int unsigned CountW       = 32;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned CfgAddrW     = 5;
  localparam int unsigned MaxPatternDefault = 16;

  typedef enum logic [1:0] {
    RegPatternLow  = 2'd0,
    RegPatternHigh = 2'd1,
    RegCareMask    = 2'd2,
    RegPatternLen  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [CountW-1:0] match_offset;
  } out_t;

  typedef struct packed {
    logic [8*PatternBytes-1:0] pattern;
    logic [PatternBytes-1:0]   care_mask;
    logic [LenW-1:0]           length;
  } cfg_t;

endpackage

[design/wbps_match.sv]
module wbps_match
  import wbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPatternDefault
) (
  input  logic [MAX_PATTERN-1:0][7:0] window_i,
  input  cfg_t                        cfg_i,
  output logic                        match_o
);

  logic mismatch;

  // Window entry 0 is the newest byte, so pattern byte j lines up with
  // entry (length - 1 - j).
  always_comb begin
    mismatch = 1'b0;
    for (int unsigned j = 0; j < MAX_PATTERN; j++) begin
      for (int unsigned p = 0; p < MAX_PATTERN; p++) begin
        if (cfg_i.care_mask[j] && (cfg_i.length == LenW'(p + j + 1)) &&
            (window_i[p] != cfg_i.pattern[8*j +: 8])) begin
          mismatch = 1'b1;
        end
      end
    end
  end

  assign match_o = (cfg_i.length != '0) &&
                   ({1'b0, cfg_i.length} <= (LenW + 1)'(MAX_PATTERN)) && !mismatch;

endmodule

[design/wildcard_byte_pattern_search.sv]
// A result is registered into the result queue and is driven on out_rsp_o from its head entry.
// One byte per cycle is accepted while the skid entry is empty; the full window compare and
// the saturating byte count both complete in the cycle the byte is accepted.
// A two-entry result queue lets input continue while a result waits on out_ready_i.
// Reset clears the configuration registers, byte count, match flag and result queue.
module wildcard_byte_pattern_search
  import wbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPatternDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_req_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_rsp_o,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t                        cfg_q;
  logic [MAX_PATTERN-1:0][7:0] window_q, window_d;
  logic [CountW-1:0]           seen_q, seen_d, seen_inc;
  logic                        reported_q, reported_d;

  out_t                        head_q, head_d, skid_q, skid_d, result;
  logic                        head_valid_q, head_valid_d, skid_valid_q, skid_valid_d;

  logic                        accept, push, pop, match, enough;
  cfg_reg_e                    reg_sel;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[CfgAddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        RegPatternLow:  cfg_q.pattern[63:0]   <= pwdata;
        RegPatternHigh: cfg_q.pattern[127:64] <= pwdata;
        RegCareMask:    cfg_q.care_mask       <= pwdata[PatternBytes-1:0];
        RegPatternLen:  cfg_q.length          <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegPatternLow:  prdata = cfg_q.pattern[63:0];
      RegPatternHigh: prdata = cfg_q.pattern[127:64];
      RegCareMask:    prdata = {{(CfgDataW-PatternBytes){1'b0}}, cfg_q.care_mask};
      RegPatternLen:  prdata = {{(CfgDataW-LenW){1'b0}}, cfg_q.length};
      default:        prdata = '0;
    endcase
  end

  // Scan datapath.
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    window_d[0] = in_req_i.data_byte;
    for (int unsigned k = 1; k < MAX_PATTERN; k++) begin
      window_d[k] = window_q[k-1];
    end
  end

  assign seen_inc = (seen_q == '1) ? seen_q : seen_q + 1'b1;
  assign enough   = (seen_inc[CountW-1:LenW] != '0) || (seen_inc[LenW-1:0] >= cfg_q.length);

  wbps_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .window_i(window_d),
    .cfg_i   (cfg_q),
    .match_o (match)
  );

  always_comb begin
    seen_d     = seen_q;
    reported_d = reported_q;
    push       = 1'b0;
    result     = '0;
    if (accept) begin
      if (reported_q) begin
        // The rest of a buffer after its match is dropped.
        if (in_req_i.last_byte) begin
          seen_d     = '0;
          reported_d = 1'b0;
        end
      end else if (match && enough) begin
        push                = 1'b1;
        result.found        = 1'b1;
        result.match_offset = seen_inc - {{(CountW-LenW){1'b0}}, cfg_q.length};
        seen_d              = in_req_i.last_byte ? '0 : seen_inc;
        reported_d          = !in_req_i.last_byte;
      end else if (in_req_i.last_byte) begin
        push   = 1'b1;
        seen_d = '0;
      end else begin
        seen_d = seen_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !reported_q) begin
      window_q <= window_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else begin
      seen_q     <= seen_d;
      reported_q <= reported_d;
    end
  end

  // Two-entry result queue: head drives the outputs, skid catches a result
  // produced while the head is stalled.
  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = head_valid_q;
  assign out_rsp_o   = head_q;
  assign pop         = head_valid_q && out_ready_i;

  always_comb begin
    head_d       = head_q;
    head_valid_d = head_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (head_valid_q && !pop) begin
      if (push) begin
        skid_d       = result;
        skid_valid_d = 1'b1;
      end
    end else if (skid_valid_q) begin
      head_d       = skid_q;
      head_valid_d = 1'b1;
      skid_valid_d = 1'b0;
    end else begin
      head_d       = result;
      head_valid_d = push;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

endmodule
